[rtl/core/fpba_pkg.sv]
// Package for the fit-policy block allocator.
// Holds sizes, codes, state type and the structs shared by the cell row and
// the sequencer. Depends on nothing.
package fpba_pkg;

	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_BITS = 16;
	localparam int AMT_W = 16;
	localparam int BLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

	typedef logic [SIZE_BITS-1:0] size_t;
	typedef logic [AMT_W-1:0] amt_t;
	typedef logic [BLK_W-1:0] blk_t;
	typedef logic [CMP_W-1:0] cmp_t;
	typedef logic [3:0] out_blk_t;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam logic [1:0] ST_LOADED = 2'd0;
	localparam logic [1:0] ST_GRANTED = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	localparam logic CFG_POLICY = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	// Best candidate found so far, handed from cell to cell.
	typedef struct packed {
		logic found;
		blk_t index;
		size_t size;
	} cand_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		logic load_en;
		blk_t load_index;
		size_t load_size;
		logic commit_en;
		blk_t commit_index;
		amt_t req_amount;
		logic [1:0] policy;
	} cell_ctrl_t;

endpackage

[rtl/core/fpba_cell.sv]
// One cell of the allocator row: holds one block's free size and updates the
// running candidate passed in from its lower-index neighbor.
// Depends on fpba_pkg.
module fpba_cell (
	input logic clk,
	input logic arst_n,
	input fpba_pkg::blk_t cell_index,
	input logic in_use,
	input fpba_pkg::cell_ctrl_t ctrl,
	input fpba_pkg::cand_t cand_in,
	output fpba_pkg::cand_t cand_out
);

	fpba_pkg::size_t size_q;
	fpba_pkg::cand_t cand_q;
	fpba_pkg::cand_t cand_nxt;
	logic eligible;
	logic take;
	logic is_best;
	logic is_worst;

	assign is_best = (ctrl.policy == fpba_pkg::POL_BEST);
	assign is_worst = (ctrl.policy == fpba_pkg::POL_WORST);
	assign eligible = in_use &&
		(fpba_pkg::cmp_t'(size_q) >= fpba_pkg::cmp_t'(ctrl.req_amount));

	// Strict compares keep the lower index on ties.
	always_comb begin
		take = eligible && (!cand_in.found ||
			(is_best && (size_q < cand_in.size)) ||
			(is_worst && (size_q > cand_in.size)));
		cand_nxt = cand_in;
		if (take) begin
			cand_nxt.found = 1'b1;
			cand_nxt.index = cell_index;
			cand_nxt.size = size_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			cand_q <= '0;
		end else begin
			cand_q <= cand_nxt;
			if (ctrl.load_en && (ctrl.load_index == cell_index)) begin
				size_q <= ctrl.load_size;
			end else if (ctrl.commit_en && (ctrl.commit_index == cell_index)) begin
				size_q <= fpba_pkg::size_t'(fpba_pkg::cmp_t'(size_q) -
					fpba_pkg::cmp_t'(ctrl.req_amount));
			end
		end
	end

	assign cand_out = cand_q;

endmodule

[rtl/core/fpba_ctrl.sv]
// Sequencer of the allocator: takes requests, times the scan over the cell
// row, commits the grant and registers the result. Depends on fpba_pkg.
module fpba_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic req_type,
	input logic [3:0] block_index,
	input fpba_pkg::amt_t amount,
	input logic [1:0] policy,
	input fpba_pkg::cand_t cand_last,
	output logic busy,
	output fpba_pkg::cell_ctrl_t ctrl,
	output logic done,
	output logic [1:0] status,
	output fpba_pkg::out_blk_t chosen_block,
	output fpba_pkg::amt_t size_left
);

	localparam int CNT_W = fpba_pkg::BLK_W;

	fpba_pkg::state_t state_q;
	fpba_pkg::state_t state_nxt;
	logic [CNT_W-1:0] cnt_q;
	fpba_pkg::amt_t amt_q;
	logic accept;
	logic in_table;
	logic scan_last;
	logic done_q;
	logic [1:0] status_q;
	fpba_pkg::out_blk_t chosen_q;
	fpba_pkg::amt_t left_q;
	fpba_pkg::size_t granted_left;

	assign busy = (state_q != fpba_pkg::S_IDLE);
	assign accept = start && !busy;
	assign in_table = (int'(block_index) < fpba_pkg::NUM_BLOCKS);
	assign scan_last = (cnt_q == CNT_W'(fpba_pkg::NUM_BLOCKS - 1));
	assign granted_left = fpba_pkg::size_t'(fpba_pkg::cmp_t'(cand_last.size) -
		fpba_pkg::cmp_t'(amt_q));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fpba_pkg::S_IDLE: begin
				if (accept && (req_type == fpba_pkg::REQ_ALLOC)) begin
					state_nxt = fpba_pkg::S_SCAN;
				end
			end
			fpba_pkg::S_SCAN: begin
				if (scan_last) begin
					state_nxt = fpba_pkg::S_COMMIT;
				end
			end
			fpba_pkg::S_COMMIT: state_nxt = fpba_pkg::S_IDLE;
			default: state_nxt = fpba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl.load_en = accept && (req_type == fpba_pkg::REQ_LOAD) && in_table;
		ctrl.load_index = fpba_pkg::blk_t'(block_index);
		ctrl.load_size = fpba_pkg::size_t'(amount);
		ctrl.commit_en = 1'b0;
		ctrl.commit_index = cand_last.index;
		ctrl.req_amount = amt_q;
		ctrl.policy = policy;
		case (state_q)
			fpba_pkg::S_COMMIT: ctrl.commit_en = cand_last.found;
			default: ctrl.commit_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpba_pkg::S_IDLE;
			cnt_q <= '0;
			amt_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q <= 1'b0;
			if (accept) begin
				amt_q <= amount;
				cnt_q <= '0;
				done_q <= (req_type == fpba_pkg::REQ_LOAD);
			end else if (state_q == fpba_pkg::S_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == fpba_pkg::S_COMMIT) begin
				done_q <= 1'b1;
			end
		end
	end

	// Result payload, captured on the cycle the result is decided.
	always_ff @(posedge clk) begin
		if (accept && (req_type == fpba_pkg::REQ_LOAD)) begin
			status_q <= fpba_pkg::ST_LOADED;
			chosen_q <= block_index;
			left_q <= in_table ? fpba_pkg::amt_t'(fpba_pkg::size_t'(amount)) : '0;
		end else if (state_q == fpba_pkg::S_COMMIT) begin
			if (cand_last.found) begin
				status_q <= fpba_pkg::ST_GRANTED;
				chosen_q <= fpba_pkg::out_blk_t'(cand_last.index);
				left_q <= fpba_pkg::amt_t'(granted_left);
			end else begin
				status_q <= fpba_pkg::ST_REFUSED;
				chosen_q <= '0;
				left_q <= '0;
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign chosen_block = chosen_q;
	assign size_left = left_q;

endmodule

[rtl/core/fit_policy_block_allocator.sv]
// Top level of the fit-policy block allocator: configuration registers, the
// row of block cells and the sequencer. Depends on fpba_pkg, fpba_cell and
// fpba_ctrl.
//
// Usage. A request is taken at a rising edge with start high and busy low.
// req_type selects a load (write amount as the free size of block_index) or
// an allocate (find a block with at least amount free, by the policy in
// register fit_policy: first, best or worst fit, ties to the lower index).
// Each request gives one result on status, chosen_block and size_left,
// valid for exactly one cycle while done is high; the receiver cannot stall
// it, so it must take the result in that cycle.
//
// Request flow. A load gives its result in the next cycle and a new request may
// follow at once. An allocate runs a candidate wave down the cell row, one
// cell per cycle, through the scan state; then the commit state subtracts the
// request from the chosen cell and registers the result. busy stays high
// through the scan and commit states, so no new request is taken while an
// allocate is in flight. Only blocks below block_count take part.
//
// Reset clears every free size to zero, sets fit_policy to first fit and
// block_count to 16. The user writes configuration through cfg_we, cfg_index
// and cfg_data only while no request is in flight; the block does not check.
module fit_policy_block_allocator (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic req_type,
	input logic [3:0] block_index,
	input logic [15:0] amount,
	output logic done,
	output logic [1:0] status,
	output logic [3:0] chosen_block,
	output logic [15:0] size_left,
	input logic cfg_we,
	input logic cfg_index,
	input logic [4:0] cfg_data
);

	logic [1:0] policy_q;
	logic [4:0] count_q;
	fpba_pkg::cell_ctrl_t ctrl;
	fpba_pkg::cand_t chain [fpba_pkg::NUM_BLOCKS+1];

	// Configuration registers; a write takes effect at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= fpba_pkg::POL_FIRST;
			count_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				fpba_pkg::CFG_POLICY: policy_q <= cfg_data[1:0];
				fpba_pkg::CFG_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The wave enters the row with no candidate found.
	assign chain[0] = '0;

	// Each cell adds its block to the candidate and hands it up the row. A
	// count above the table size simply enables every cell.
	for (genvar i = 0; i < fpba_pkg::NUM_BLOCKS; i++) begin : g_cell
		fpba_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cell_index(fpba_pkg::blk_t'(i)),
			.in_use(i < int'(count_q)),
			.ctrl(ctrl),
			.cand_in(chain[i]),
			.cand_out(chain[i+1])
		);
	end

	fpba_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_type(req_type),
		.block_index(block_index),
		.amount(amount),
		.policy(policy_q),
		.cand_last(chain[fpba_pkg::NUM_BLOCKS]),
		.busy(busy),
		.ctrl(ctrl),
		.done(done),
		.status(status),
		.chosen_block(chosen_block),
		.size_left(size_left)
	);

endmodule
